FILE: rtl/cprb_pkg.sv
// Package for the card punch row-binary buffer.
// Holds the operation codes, widths, defaults and the command passed from front to back.
// No dependencies.
`default_nettype none
package cprb_pkg;

  localparam int HALF_COLUMNS_DEFAULT   = 36;
  localparam int WORDS_PER_CARD_DEFAULT = 24;
  localparam int WORD_BITS              = 36;
  localparam int ROW_BITS               = 12;
  localparam int ROW_SEL_BITS           = 4;
  localparam int POS_BITS               = 5;
  localparam int OP_BITS                = 3;
  localparam int COL_BITS               = 6;

  localparam logic [OP_BITS-1:0] OP_START      = 3'd0;
  localparam logic [OP_BITS-1:0] OP_DATA       = 3'd1;
  localparam logic [OP_BITS-1:0] OP_END_RECORD = 3'd2;
  localparam logic [OP_BITS-1:0] OP_TIME_ERROR = 3'd3;
  localparam logic [OP_BITS-1:0] OP_DISCONNECT = 3'd4;

  typedef enum logic [1:0] {
    CMD_STATUS = 2'd0,
    CMD_MERGE  = 2'd1,
    CMD_CARD   = 2'd2
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t                kind;
    logic                     status;
    logic                     attention;
    logic                     record_end;
    logic                     emit;
    logic                     half;
    logic [ROW_SEL_BITS-1:0]  row;
    logic [WORD_BITS-1:0]     data;
  } cmd_t;

endpackage
`default_nettype wire

FILE: rtl/card_punch_row_binary_buffer.sv
// Card punch row-binary buffer: a front end that classifies channel transactions, a
// two-entry command queue and a back end holding the card image. Uses cprb_pkg,
// cprb_front, cprb_queue and cprb_back. The front end takes one input transaction per
// cycle while the queue has room. A status result passes through the queue and then the
// output register; a data word is merged into the image as it leaves the queue; and a
// card walks its column pairs out of the image shift lines, which clears the image as it
// goes, pausing while the output register still holds an untaken result. An output
// register holds each result until it is taken.
`default_nettype none
module card_punch_row_binary_buffer #(
  parameter int HALF_COLUMNS   = cprb_pkg::HALF_COLUMNS_DEFAULT,
  parameter int WORDS_PER_CARD = cprb_pkg::WORDS_PER_CARD_DEFAULT
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic                           unit_attached,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic [cprb_pkg::OP_BITS-1:0]   op,
  input  wire logic [cprb_pkg::WORD_BITS-1:0] data_word,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic                                is_card,
  output logic                                status,
  output logic                                attention,
  output logic                                record_end,
  output logic [cprb_pkg::COL_BITS-1:0]       column_index,
  output logic [cprb_pkg::ROW_BITS-1:0]       left_rows,
  output logic [cprb_pkg::ROW_BITS-1:0]       right_rows,
  output logic                                last
);
  import cprb_pkg::*;

  logic attached;
  logic push;
  cmd_t push_cmd;
  logic queue_full;
  logic queue_empty;
  logic pop;
  cmd_t head;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      attached <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      attached <= unit_attached;
    end
  end

  cprb_front #(
    .WORDS_PER_CARD(WORDS_PER_CARD)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .unit_attached(attached),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .op           (op),
    .data_word    (data_word),
    .push         (push),
    .push_cmd     (push_cmd),
    .queue_full   (queue_full)
  );

  cprb_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .push_cmd(push_cmd),
    .full    (queue_full),
    .pop     (pop),
    .head    (head),
    .empty   (queue_empty)
  );

  cprb_back #(
    .HALF_COLUMNS(HALF_COLUMNS)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .head        (head),
    .empty       (queue_empty),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .is_card     (is_card),
    .status      (status),
    .attention   (attention),
    .record_end  (record_end),
    .column_index(column_index),
    .left_rows   (left_rows),
    .right_rows  (right_rows),
    .last        (last)
  );

endmodule
`default_nettype wire

FILE: rtl/cprb_front.sv
// Front end of the card punch buffer: accepts input transactions and classifies them.
// Keeps busy and word position and issues commands to the queue; uses cprb_pkg.
`default_nettype none
module cprb_front #(
  parameter int WORDS_PER_CARD = cprb_pkg::WORDS_PER_CARD_DEFAULT
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           unit_attached,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic [cprb_pkg::OP_BITS-1:0]   op,
  input  wire logic [cprb_pkg::WORD_BITS-1:0] data_word,
  output logic                                push,
  output cprb_pkg::cmd_t                      push_cmd,
  input  wire logic                           queue_full
);
  import cprb_pkg::*;

  logic                busy;
  logic                busy_next;
  logic [POS_BITS-1:0] word_position;
  logic [POS_BITS-1:0] word_position_next;
  logic [POS_BITS-1:0] pos_eff;
  logic [POS_BITS-1:0] pos_inc;
  logic                accept;

  assign in_ready = !queue_full;
  assign accept   = in_valid && in_ready;
  assign pos_eff  = (word_position >= POS_BITS'(WORDS_PER_CARD)) ? '0 : word_position;
  assign pos_inc  = pos_eff + POS_BITS'(1);

  always_comb begin
    busy_next          = busy;
    word_position_next = word_position;
    push               = 1'b0;
    push_cmd.kind       = CMD_STATUS;
    push_cmd.status     = 1'b1;
    push_cmd.attention  = 1'b1;
    push_cmd.record_end = 1'b0;
    push_cmd.emit       = 1'b0;
    push_cmd.half       = pos_eff[0];
    push_cmd.row        = pos_eff[POS_BITS-1:1];
    push_cmd.data       = data_word;
    if (accept) begin
      unique case (op)
        OP_START: begin
          push = 1'b1;
          if (unit_attached && !busy) begin
            busy_next          = 1'b1;
            word_position_next = '0;
            push_cmd.status    = 1'b0;
            push_cmd.attention = 1'b0;
          end
        end
        OP_DATA: begin
          push = 1'b1;
          if (busy) begin
            push_cmd.kind      = CMD_MERGE;
            push_cmd.status    = 1'b0;
            push_cmd.attention = 1'b0;
            if (pos_inc >= POS_BITS'(WORDS_PER_CARD)) begin
              word_position_next  = '0;
              push_cmd.emit       = 1'b1;
              push_cmd.record_end = 1'b1;
            end else begin
              word_position_next = pos_inc;
            end
          end
        end
        OP_END_RECORD: begin
          push = 1'b1;
          if (busy) begin
            word_position_next  = '0;
            push_cmd.kind       = CMD_CARD;
            push_cmd.status     = 1'b0;
            push_cmd.attention  = 1'b0;
            push_cmd.record_end = 1'b1;
          end
        end
        OP_TIME_ERROR: begin
          push = 1'b1;
          if (busy) begin
            word_position_next = '0;
            push_cmd.kind      = CMD_CARD;
            push_cmd.status    = 1'b0;
          end
        end
        OP_DISCONNECT: begin
          if (busy) begin
            busy_next          = 1'b0;
            word_position_next = '0;
            push               = (word_position != '0);
            push_cmd.kind      = CMD_CARD;
            push_cmd.status    = 1'b0;
            push_cmd.attention = 1'b0;
          end
        end
        default: begin
          push = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy          <= 1'b0;
      word_position <= '0;
    end else begin
      busy          <= busy_next;
      word_position <= word_position_next;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/cprb_queue.sv
// Two-entry command queue between the front and back of the card punch buffer.
// Stores cmd_t entries from cprb_pkg.
`default_nettype none
module cprb_queue (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push,
  input  wire cprb_pkg::cmd_t push_cmd,
  output logic                full,
  input  wire logic           pop,
  output cprb_pkg::cmd_t      head,
  output logic                empty
);
  import cprb_pkg::*;

  cmd_t       entries [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       do_push;
  logic       do_pop;

  assign full    = (count == 2'd2);
  assign empty   = (count == 2'd0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= !wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + 2'(do_push) - 2'(do_pop);
    end
  end

endmodule
`default_nettype wire

FILE: rtl/cprb_back.sv
// Back end of the card punch buffer: holds the column image and carries out commands.
// Merges words into two shift lines of columns and walks them out as results; uses cprb_pkg.
`default_nettype none
module cprb_back #(
  parameter int HALF_COLUMNS = cprb_pkg::HALF_COLUMNS_DEFAULT
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire cprb_pkg::cmd_t                head,
  input  wire logic                          empty,
  output logic                               pop,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic                               is_card,
  output logic                               status,
  output logic                               attention,
  output logic                               record_end,
  output logic [cprb_pkg::COL_BITS-1:0]      column_index,
  output logic [cprb_pkg::ROW_BITS-1:0]      left_rows,
  output logic [cprb_pkg::ROW_BITS-1:0]      right_rows,
  output logic                               last
);
  import cprb_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EMIT = 2'b10
  } state_t;

  state_t                state;
  state_t                state_next;
  logic [ROW_BITS-1:0]   left_image       [HALF_COLUMNS];
  logic [ROW_BITS-1:0]   right_image      [HALF_COLUMNS];
  logic [ROW_BITS-1:0]   left_image_next  [HALF_COLUMNS];
  logic [ROW_BITS-1:0]   right_image_next [HALF_COLUMNS];
  logic [COL_BITS-1:0]   column;
  logic                  card_attention;
  logic                  card_record_end;
  logic                  out_free;
  logic                  merge_en;
  logic                  shift_en;
  logic                  final_column;
  logic [ROW_BITS-1:0]   row_bit;

  assign out_free     = !out_valid || out_ready;
  assign pop          = (state == ST_IDLE) && !empty && ((head.kind != CMD_STATUS) || out_free);
  assign merge_en     = pop && (head.kind == CMD_MERGE);
  assign shift_en     = (state == ST_EMIT) && out_free;
  assign final_column = (column == COL_BITS'(HALF_COLUMNS - 1));
  assign row_bit      = (head.row < ROW_SEL_BITS'(ROW_BITS)) ? (ROW_BITS'(1) << head.row) : '0;

  for (genvar c = 0; c < HALF_COLUMNS; c++) begin : g_col
    logic hit;
    logic [ROW_BITS-1:0] left_shift_in;
    logic [ROW_BITS-1:0] right_shift_in;
    if (HALF_COLUMNS - 1 - c < WORD_BITS) begin : g_hit
      assign hit = head.data[HALF_COLUMNS-1-c];
    end else begin : g_nohit
      assign hit = 1'b0;
    end
    if (c < HALF_COLUMNS - 1) begin : g_shift
      assign left_shift_in  = left_image[c+1];
      assign right_shift_in = right_image[c+1];
    end else begin : g_end
      assign left_shift_in  = '0;
      assign right_shift_in = '0;
    end
    always_comb begin
      left_image_next[c]  = left_image[c];
      right_image_next[c] = right_image[c];
      if (merge_en && hit) begin
        if (head.half) begin
          right_image_next[c] = right_image[c] | row_bit;
        end else begin
          left_image_next[c] = left_image[c] | row_bit;
        end
      end else if (shift_en) begin
        left_image_next[c]  = left_shift_in;
        right_image_next[c] = right_shift_in;
      end
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (pop && ((head.kind == CMD_CARD) || head.emit)) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (shift_en && final_column) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int c = 0; c < HALF_COLUMNS; c++) begin
        left_image[c]  <= '0;
        right_image[c] <= '0;
      end
    end else begin
      for (int c = 0; c < HALF_COLUMNS; c++) begin
        left_image[c]  <= left_image_next[c];
        right_image[c] <= right_image_next[c];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      column    <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (pop) begin
        column <= '0;
      end else if (shift_en) begin
        column <= column + COL_BITS'(1);
      end
      if (pop && (head.kind == CMD_STATUS)) begin
        out_valid <= 1'b1;
      end else if (shift_en) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      card_attention  <= head.attention;
      card_record_end <= head.record_end;
    end
    if (pop && (head.kind == CMD_STATUS)) begin
      is_card      <= 1'b0;
      status       <= head.status;
      attention    <= head.attention;
      record_end   <= 1'b0;
      column_index <= '0;
      left_rows    <= '0;
      right_rows   <= '0;
      last         <= 1'b1;
    end else if (shift_en) begin
      is_card      <= 1'b1;
      status       <= 1'b0;
      attention    <= card_attention;
      record_end   <= card_record_end;
      column_index <= column;
      left_rows    <= left_image[0];
      right_rows   <= right_image[0];
      last         <= final_column;
    end
  end

endmodule
`default_nettype wire
